### src/rsch_pkg.sv
`timescale 1ns / 1ps
package rsch_pkg;

  localparam int COORD_W    = 16;
  localparam int OPND_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int REM_W      = ACC_W + 1;
  localparam int DIST_FRAC  = 8;
  localparam int DIST_W     = 24;
  localparam int Q_STEPS    = 24;
  localparam int Q_CNT_W    = 5;
  localparam int CFG_AW     = 5;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_DIR_X     = 3'd2;
  localparam logic [2:0] REG_DIR_Y     = 3'd3;
  localparam logic [2:0] REG_MAX_RANGE = 3'd4;

  typedef struct packed {
    logic signed [OPND_W-1:0]  wx;
    logic signed [OPND_W-1:0]  wy;
    logic signed [OPND_W-1:0]  ex;
    logic signed [OPND_W-1:0]  ey;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } cross_op_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] den;
    logic signed [ACC_W-1:0] num_u;
    logic signed [ACC_W-1:0] num_t;
  } cross_res_t;

  typedef struct packed {
    logic [ACC_W-1:0]  num;
    logic [ACC_W-1:0]  den;
    logic [DIST_W-1:0] limit;
  } div_req_t;

endpackage

### src/rsch_cross.sv
`timescale 1ns / 1ps
module rsch_cross import rsch_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cross_op_t  op,
  output cross_res_t res,
  output logic       done
);

  typedef enum logic [2:0] {
    P_DEN_A, P_DEN_B, P_NU_A, P_NU_B, P_NT_A, P_NT_B, P_END
  } term_t;

  term_t                    step;
  term_t                    pidx;
  logic                     busy;
  logic signed [OPND_W-1:0] a;
  logic signed [OPND_W-1:0] b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  pext;

  always_comb begin
    case (step)
      P_DEN_A: begin a = {op.dx[COORD_W-1], op.dx}; b = op.ey; end
      P_DEN_B: begin a = {op.dy[COORD_W-1], op.dy}; b = op.ex; end
      P_NU_A:  begin a = op.wx; b = {op.dy[COORD_W-1], op.dy}; end
      P_NU_B:  begin a = op.wy; b = {op.dx[COORD_W-1], op.dx}; end
      P_NT_A:  begin a = op.wx; b = op.ey; end
      P_NT_B:  begin a = op.wy; b = op.ex; end
      default: begin a = '0; b = '0; end
    endcase
  end

  assign pext = {prod[PROD_W-1], prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= P_DEN_A;
      pidx <= P_DEN_A;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= P_DEN_A;
        res.den   <= '0;
        res.num_u <= '0;
        res.num_t <= '0;
      end else if (busy) begin
        prod <= a * b;
        pidx <= step;
        if (step != P_DEN_A) begin
          case (pidx)
            P_DEN_A: res.den   <= res.den + pext;
            P_DEN_B: res.den   <= res.den - pext;
            P_NU_A:  res.num_u <= res.num_u + pext;
            P_NU_B:  res.num_u <= res.num_u - pext;
            P_NT_A:  res.num_t <= res.num_t + pext;
            P_NT_B:  res.num_t <= res.num_t - pext;
            default: ;
          endcase
        end
        if (step == P_END) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= term_t'(step + 3'd1);
        end
      end
    end
  end

endmodule

### src/rsch_div.sv
`timescale 1ns / 1ps
module rsch_div import rsch_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  div_req_t          req,
  output logic [DIST_W-1:0] quot,
  output logic              done
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t            state;
  logic [Q_CNT_W-1:0] cnt;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   den;
  logic [DIST_W-1:0]  q;
  logic [DIST_W-1:0]  limit;
  logic               fb;
  logic [REM_W-1:0]   trial;
  logic               sat;

  assign trial = {rem[REM_W-2:0], fb};
  assign sat   = {1'b0, req.num} >= {req.den, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            den   <= {1'b0, req.den};
            limit <= req.limit;
            rem   <= {2'b00, req.num[ACC_W-1:1]};
            fb    <= req.num[0];
            cnt   <= '0;
            q     <= '1;
            state <= sat ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          fb <= 1'b0;
          if (trial >= den) begin
            rem <= trial - den;
            q   <= {q[DIST_W-2:0], 1'b1};
          end else begin
            rem <= trial;
            q   <= {q[DIST_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == Q_CNT_W'(Q_STEPS - 1)) state <= D_FIN;
        end
        D_FIN: begin
          quot  <= (q < limit) ? q : limit;
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

### src/ray_segment_closest_hit.sv
`timescale 1ns / 1ps
// One segment word at a time: each runs seven shared 17x17 multiplier steps, and a
// hit then 24 restoring-divider quotient bits, one per cycle, unless its quotient
// would overflow 24 bits, which skips the divider loop.
// The result word goes valid in the cycle ready returns after the segment
// marked last; a stalled earlier result word holds both back.
// Synchronous active-high reset restores register defaults and clears the control and output state.
module ray_segment_closest_hit import rsch_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
  input  logic [63:0]       s_tdata,
  // last_segment
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  // distance[23:0]
  output logic [23:0]       m_tdata,
  // hit
  output logic              m_tuser
);

  typedef enum logic [2:0] {S_IDLE, S_CROSS, S_TEST, S_DIV, S_DONE} state_t;

  state_t                    state;
  logic signed [COORD_W-1:0] origin_x, origin_y, dir_x, dir_y;
  logic [COORD_W-1:0]        max_range;
  cross_op_t                 op;
  cross_res_t                res;
  div_req_t                  req;
  logic                      cross_start, cross_done;
  logic                      div_start, div_done;
  logic [DIST_W-1:0]         div_q;
  logic                      last;
  logic [DIST_W-1:0]         best;
  logic                      found;
  logic signed [COORD_W-1:0] sx, sy, ex_in, ey_in;
  logic                      neg, hit;
  logic [ACC_W-1:0]          den_a, nu_a, nt_a;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);

  assign sx    = s_tdata[15:0];
  assign sy    = s_tdata[31:16];
  assign ex_in = s_tdata[47:32];
  assign ey_in = s_tdata[63:48];

  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_X:  prdata = {{16{origin_x[15]}}, origin_x};
      REG_ORIGIN_Y:  prdata = {{16{origin_y[15]}}, origin_y};
      REG_DIR_X:     prdata = {{16{dir_x[15]}}, dir_x};
      REG_DIR_Y:     prdata = {{16{dir_y[15]}}, dir_y};
      REG_MAX_RANGE: prdata = {16'd0, max_range};
      default:       prdata = 32'd0;
    endcase
  end

  assign neg   = res.den[ACC_W-1];
  assign den_a = neg ? -res.den : res.den;
  assign nu_a  = neg ? -res.num_u : res.num_u;
  assign nt_a  = neg ? -res.num_t : res.num_t;
  assign hit   = (res.den != '0) && !nt_a[ACC_W-1] && !nu_a[ACC_W-1] && (nu_a <= den_a);

  rsch_cross u_cross (
    .clk   (clk),
    .rst   (rst),
    .start (cross_start),
    .op    (op),
    .res   (res),
    .done  (cross_done)
  );

  rsch_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (req),
    .quot  (div_q),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      origin_x    <= '0;
      origin_y    <= '0;
      dir_x       <= 16'sd32767;
      dir_y       <= '0;
      max_range   <= 16'd1280;
      cross_start <= 1'b0;
      div_start   <= 1'b0;
      best        <= '1;
      found       <= 1'b0;
      m_tvalid    <= 1'b0;
      m_tuser     <= 1'b0;
      m_tdata     <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          REG_ORIGIN_X:  origin_x  <= pwdata[15:0];
          REG_ORIGIN_Y:  origin_y  <= pwdata[15:0];
          REG_DIR_X:     dir_x     <= pwdata[15:0];
          REG_DIR_Y:     dir_y     <= pwdata[15:0];
          REG_MAX_RANGE: max_range <= pwdata[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      cross_start <= 1'b0;
      div_start   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op.wx       <= {sx[15], sx} - {origin_x[15], origin_x};
            op.wy       <= {sy[15], sy} - {origin_y[15], origin_y};
            op.ex       <= {ex_in[15], ex_in} - {sx[15], sx};
            op.ey       <= {ey_in[15], ey_in} - {sy[15], sy};
            op.dx       <= dir_x;
            op.dy       <= dir_y;
            last        <= s_tlast;
            cross_start <= 1'b1;
            state       <= S_CROSS;
          end
        end
        S_CROSS: begin
          if (cross_done) state <= S_TEST;
        end
        S_TEST: begin
          if (hit) begin
            found     <= 1'b1;
            req.num   <= nt_a;
            req.den   <= den_a;
            req.limit <= {max_range, {DIST_FRAC{1'b0}}};
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_q < best) best <= div_q;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= found;
            m_tdata  <= found ? best : '0;
            best     <= '1;
            found    <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/rsch_check.sv
`timescale 1ns / 1ps
module rsch_check import rsch_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [63:0]       s_tdata,
  input logic              s_tlast,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [23:0]       m_tdata,
  input logic              m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("distance nonzero without hit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after segment word");

  a_result_needs_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> ##1 !$rose(m_tvalid))
    else $error("result word without last segment");

endmodule

bind ray_segment_closest_hit rsch_check u_check (.*);

### sim/tb_ray_segment_closest_hit.sv
`timescale 1ns / 1ps
module tb_ray_segment_closest_hit;
  import rsch_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_ITEMS = 1330;
  localparam int STEADY_TAIL = 200;

  typedef struct {
    logic        hit;
    logic [23:0] distance;
  } hit_report_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
  logic [63:0]       s_tdata = '0;
  // last_segment
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // distance[23:0]
  logic [23:0]       m_tdata;
  // hit
  logic              m_tuser;

  // ray registers as the block should hold them
  logic signed [15:0] ray_ox = 16'sd0;
  logic signed [15:0] ray_oy = 16'sd0;
  logic signed [15:0] ray_dx = 16'sd32767;
  logic signed [15:0] ray_dy = 16'sd0;
  logic [15:0]        ray_range = 16'd1280;
  // running closest hit
  logic [23:0]        best_dist = 24'hFFFFFF;
  logic               any_hit = 1'b0;

  hit_report_t pending_hits[0:2047];
  logic [10:0] exp_wr = '0;
  logic [10:0] exp_rd = '0;
  hit_report_t got_front;
  int          mismatches = 0;
  logic        no_idle = 1'b0;
  int          rx_hold = 0;

  ray_segment_closest_hit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void track_segment(logic signed [15:0] sx, logic signed [15:0] sy,
                                        logic signed [15:0] fx, logic signed [15:0] fy,
                                        logic lst);
    longint wx, wy, ex, ey, dxl, dyl, den, nu, nt, q, lim;
    wx = longint'(sx) - longint'(ray_ox);
    wy = longint'(sy) - longint'(ray_oy);
    ex = longint'(fx) - longint'(sx);
    ey = longint'(fy) - longint'(sy);
    dxl = longint'(ray_dx);
    dyl = longint'(ray_dy);
    den = dxl * ey - dyl * ex;
    nu = wx * dyl - wy * dxl;
    nt = wx * ey - wy * ex;
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        nu = -nu;
        nt = -nt;
      end
      if (nt >= 0 && nu >= 0 && nu <= den) begin
        lim = longint'(ray_range) <<< DIST_FRAC;
        if (lim > 64'hFFFFFF) lim = 64'hFFFFFF;
        q = (nt <<< (15 + DIST_FRAC)) / den;
        if (q >= lim) q = lim;
        any_hit = 1'b1;
        if (q < longint'(best_dist)) best_dist = q[23:0];
      end
    end
    if (lst) begin
      pending_hits[exp_wr] = '{any_hit, any_hit ? best_dist : 24'd0};
      exp_wr = exp_wr + 11'd1;
      best_dist = 24'hFFFFFF;
      any_hit = 1'b0;
    end
  endfunction

  function automatic logic signed [15:0] sat16(real r);
    if (r > 32767.0) return 16'sd32767;
    if (r < -32768.0) return -16'sd32768;
    return 16'($rtoi(r));
  endfunction

  // called at a falling edge; returns at a falling edge with s_tvalid still high
  task automatic send_segment(logic signed [15:0] sx, logic signed [15:0] sy,
                              logic signed [15:0] fx, logic signed [15:0] fy, logic lst);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {fy, fx, sy, sx};
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    track_segment(sx, sy, fx, fy, lst);
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ORIGIN_X:  ray_ox = val;
      REG_ORIGIN_Y:  ray_oy = val;
      REG_DIR_X:     ray_dx = val;
      REG_DIR_Y:     ray_dy = val;
      REG_MAX_RANGE: ray_range = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_ray(logic [15:0] ox, logic [15:0] oy, logic [15:0] dx,
                         logic [15:0] dy, logic [15:0] range_px);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_MAX_RANGE, range_px);
  endtask

  // segment crossing the ray line near ray parameter t_px, at fraction u_at along it
  task automatic send_crossing(real t_px, real u_at, logic lst);
    real px, py, ang, len, cx, cy;
    px = real'(ray_ox) + t_px * real'(ray_dx) / 32768.0;
    py = real'(ray_oy) + t_px * real'(ray_dy) / 32768.0;
    ang = real'($urandom_range(0, 35999)) * 3.14159265358979 / 18000.0;
    len = real'($urandom_range(1, 1500));
    cx = len * $cos(ang);
    cy = len * $sin(ang);
    send_segment(sat16(px - u_at * cx), sat16(py - u_at * cy),
                 sat16(px + (1.0 - u_at) * cx), sat16(py + (1.0 - u_at) * cy), lst);
  endtask

  task automatic test_default_ray();
    send_segment(16'sd100, -16'sd10, 16'sd100, 16'sd10, 1'b1);
    send_segment(16'sd100, 16'sd10, 16'sd100, 16'sd20, 1'b1);
    send_segment(-16'sd50, -16'sd10, -16'sd50, 16'sd10, 1'b1);
    send_segment(16'sd10, 16'sd0, 16'sd50, 16'sd0, 1'b0);
    send_segment(16'sd60, 16'sd0, 16'sd5, 16'sd0, 1'b0);
    send_segment(16'sd30, 16'sd5, 16'sd30, 16'sd5, 1'b0);
    send_segment(16'sd50, 16'sd0, 16'sd50, 16'sd10, 1'b0);
    send_segment(16'sd2000, -16'sd5, 16'sd2000, 16'sd5, 1'b0);
    send_segment(16'sd80, 16'sd10, 16'sd80, -16'sd10, 1'b1);
    send_segment(16'sd70, -16'sd3, 16'sd70, 16'sd3, 1'b0);
    send_segment(16'sd70, 16'sd5, 16'sd70, -16'sd5, 1'b1);
    send_segment(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1);
    send_segment(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1);
    wait_results_done();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_SPARE, 16'hFFFF);
    send_segment(16'sd100, -16'sd10, 16'sd100, 16'sd10, 1'b1);
    wait_results_done();
    set_ray(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_segment(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1);
    wait_results_done();
    set_ray(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
    send_segment(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1);
    wait_results_done();
    set_ray(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
    send_segment(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
    wait_results_done();
    write_reg(REG_DIR_Y, 16'h0000);
    send_segment(16'sd100, -16'sd10, 16'sd100, 16'sd10, 1'b1);
    wait_results_done();
    set_ray(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_segment(16'sd10, -16'sd10, 16'sd10, 16'sd10, 1'b1);
    wait_results_done();
    write_reg(REG_MAX_RANGE, 16'd1280);
    send_segment(16'sd40, -16'sd4, 16'sd40, 16'sd4, 1'b0);
    send_segment(16'sd30, -16'sd9, 16'sd50, 16'sd9, 1'b1);
    wait_results_done();
  endtask

  task automatic random_ray();
    real ang;
    logic [15:0] dx, dy, range_px;
    ang = real'($urandom_range(0, 35999)) * 3.14159265358979 / 18000.0;
    if ($urandom_range(0, 9) == 0) begin
      dx = 16'($urandom);
      dy = 16'($urandom);
    end else begin
      dx = 16'(sat16(32767.0 * $cos(ang)));
      dy = 16'(sat16(32767.0 * $sin(ang)));
    end
    case ($urandom_range(0, 9))
      0: range_px = 16'd0;
      1: range_px = 16'hFFFF;
      default: range_px = 16'($urandom_range(50, 6000));
    endcase
    set_ray(16'(sat16(real'($urandom_range(0, 16000)) - 8000.0)),
            16'(sat16(real'($urandom_range(0, 16000)) - 8000.0)), dx, dy, range_px);
  endtask

  task automatic test_random_rays(int n_items);
    int sent, nseg, pick;
    logic [63:0] noise;
    logic signed [15:0] psx, psy, pfx, pfy;
    sent = 0;
    psx = 0; psy = 0; pfx = 0; pfy = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_results_done();
        random_ray();
      end
      nseg = $urandom_range(1, 12);
      for (int k = 0; k < nseg; k++) begin
        no_idle = (sent >= n_items - STEADY_TAIL);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_crossing(real'($urandom_range(0, 6200)) - 200.0,
                        real'($urandom_range(0, 1400)) / 1000.0 - 0.2, k == nseg - 1);
          psx = s_tdata[15:0]; psy = s_tdata[31:16];
          pfx = s_tdata[47:32]; pfy = s_tdata[63:48];
        end else if (pick == 7) begin
          send_segment(psx, psy, pfx, pfy, k == nseg - 1);
        end else begin
          noise = {$urandom, $urandom};
          send_segment(noise[15:0], noise[31:16], noise[47:32], noise[63:48],
                       (k == nseg - 1) || ($urandom_range(0, 7) == 0));
        end
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (no_idle) begin
      m_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      rx_hold <= $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got hit=%0d distance=%0d",
                 $time, m_tuser, m_tdata);
      end else begin
        got_front = pending_hits[exp_rd];
        exp_rd = exp_rd + 11'd1;
        if (m_tuser !== got_front.hit || m_tdata !== got_front.distance) begin
          mismatches++;
          $display("%0t: expected hit=%0d distance=%0d, got hit=%0d distance=%0d",
                   $time, got_front.hit, got_front.distance, m_tuser, m_tdata);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_ray();
    test_register_extremes();
    test_random_rays(RANDOM_ITEMS);
    wait_results_done();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
